>>> sv/nemtd_pkg.sv
// Shared types and constants for the tile decompressor.
// No dependencies; the files that use it refer to it by scoped names.
package nemtd_pkg;

   localparam int unsigned TABLE_ENTRIES = 256;
   localparam int unsigned TABLE_AW      = $clog2(TABLE_ENTRIES);
   localparam int unsigned ENTRY_W       = 11;   // length 4, run-1 3, nybble 4
   localparam int unsigned GROUPS_W      = 18;

   localparam logic [7:0] TABLE_END     = 8'hFF;
   localparam logic [7:0] SYMBOL_MARK   = 8'h80;
   localparam logic [5:0] ESCAPE_CODE   = 6'h3F;
   localparam logic [3:0] MAX_CODE_LEN  = 4'd8;

   typedef struct packed {
      logic [7:0] stream_byte;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [31:0] tile_word;
      logic        last_word;
   } rsp_type;

   typedef struct packed {
      logic [3:0] code_len;
      logic [2:0] run_m1;
      logic [3:0] nybble;
   } entry_type;

   // Control from the sequencer to the word packer.
   typedef struct packed {
      logic                load;
      logic                xor_en;
      logic [GROUPS_W-1:0] groups;
      logic                push;
      logic [3:0]          nybble;
   } pk_ctl_type;

   // Status from the word packer to the sequencer.
   typedef struct packed {
      logic ready;   // a push may be taken this cycle
      logic final_;  // the next push completes the last word
   } pk_sts_type;

endpackage

>>> sv/nemtd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module nemtd_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> sv/nemtd_word_packer.sv
// Packs nybbles into 32-bit words, applies XOR mode, counts words and
// holds the result register. Depends on nemtd_pkg.
module nemtd_word_packer (
   input  logic                 clock,
   input  logic                 reset,
   input  nemtd_pkg::pk_ctl_type ctl,
   output nemtd_pkg::pk_sts_type sts,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output nemtd_pkg::rsp_type    rsp_data
);

   logic [31:0]                    acc_ff, acc_in;
   logic [2:0]                     held_ff, held_in;
   logic [31:0]                    prev_ff, prev_in;
   logic                           xor_ff, xor_in;
   logic [nemtd_pkg::GROUPS_W-1:0] groups_ff, groups_in;
   logic                           valid_ff, valid_in;
   nemtd_pkg::rsp_type             data_ff, data_in;
   logic [31:0]                    word;
   logic [31:0]                    acc_next;

   assign sts.ready  = !((held_ff == 3'd7) && valid_ff && !rsp_ready);
   assign sts.final_ = (held_ff == 3'd7) &&
                       (groups_ff == nemtd_pkg::GROUPS_W'(1));

   always_comb begin
      acc_in    = acc_ff;
      held_in   = held_ff;
      prev_in   = prev_ff;
      xor_in    = xor_ff;
      groups_in = groups_ff;
      valid_in  = valid_ff && !rsp_ready;
      data_in   = data_ff;
      acc_next  = {acc_ff[27:0], ctl.nybble};
      word      = acc_next ^ (xor_ff ? prev_ff : 32'd0);
      if (ctl.load) begin
         acc_in    = 32'd0;
         held_in   = 3'd0;
         prev_in   = 32'd0;
         xor_in    = ctl.xor_en;
         groups_in = ctl.groups;
      end else if (ctl.push) begin
         held_in = held_ff + 3'd1;
         if (held_ff == 3'd7) begin
            acc_in    = 32'd0;
            groups_in = groups_ff - nemtd_pkg::GROUPS_W'(1);
            if (xor_ff) begin
               prev_in = word;
            end
            valid_in          = 1'b1;
            data_in.tile_word = word;
            data_in.last_word = (groups_ff == nemtd_pkg::GROUPS_W'(1));
         end else begin
            acc_in = acc_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff   <= 3'd0;
         xor_ff    <= 1'b0;
         groups_ff <= '0;
         valid_ff  <= 1'b0;
         acc_ff    <= 32'd0;
         prev_ff   <= 32'd0;
      end else begin
         held_ff   <= held_in;
         xor_ff    <= xor_in;
         groups_ff <= groups_in;
         valid_ff  <= valid_in;
         acc_ff    <= acc_in;
         prev_ff   <= prev_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

>>> sv/nemesis_tile_decompressor_top.sv
// Top level of the tile decompressor: header and code-table sequencer,
// prefix table RAM, bit window and decode loop. Depends on nemtd_pkg,
// nemtd_ram and nemtd_word_packer.
//
// Header and table bytes are accepted one per cycle; a code-table byte
// that covers 2^(8-len) table entries holds input while they are written
// (one RAM write per cycle, at most 128 entries). While decoding, a table
// code is read from the RAM, then used, then its nybbles are emitted one
// per cycle; an escape marker is read, then its run and nybble are taken,
// then its nybbles are emitted; an unknown code is read and one bit is
// skipped. A nybble that completes a word waits while the previous
// word is still unaccepted, and a word appears on rsp in the cycle after
// its eighth nybble. Reset: synchronous; table valid bits cleared, block
// waits for a marked byte; table RAM contents are never used until written.
module nemesis_tile_decompressor_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  nemtd_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output nemtd_pkg::rsp_type rsp_data
);

   typedef enum logic [3:0] {
      ST_WAIT, ST_HDR_LO, ST_TBL_FIRST, ST_TBL_BODY, ST_TBL_CODE,
      ST_FILL, ST_LOOK, ST_TBL_READ, ST_EMIT
   } state_type;

   state_type                       state_ff, state_in;
   logic                            esc_ff, esc_in;       // escape awaits run and nybble
   logic [6:0]                      hdr_hi_ff, hdr_hi_in;
   logic                            xor_ff, xor_in;
   logic [3:0]                      sym_ff, sym_in;
   logic [7:0]                      code_hdr_ff, code_hdr_in;
   logic [15:0]                     window_ff, window_in;
   logic [4:0]                      held_ff, held_in;
   logic [nemtd_pkg::TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [7:0]                      base_ff, base_in;
   logic [6:0]                      fill_i_ff, fill_i_in;
   logic [6:0]                      fill_last_ff, fill_last_in;
   nemtd_pkg::entry_type            fill_ent_ff, fill_ent_in;
   logic [7:0]                      look_ff, look_in;
   logic [2:0]                      run_ff, run_in;
   logic [3:0]                      nyb_ff, nyb_in;

   logic                            accept;
   logic                            have_bits;
   logic [7:0]                      look;
   logic [6:0]                      esc_bits;
   logic [3:0]                      code_len;
   logic [2:0]                      shamt;
   logic [14:0]                     count;
   logic                            ram_we;
   logic [nemtd_pkg::TABLE_AW-1:0]  ram_waddr;
   logic [nemtd_pkg::ENTRY_W-1:0]   ram_rdata;
   nemtd_pkg::entry_type            rd_ent;
   nemtd_pkg::pk_ctl_type           pk_ctl;
   nemtd_pkg::pk_sts_type           pk_sts;

   // Window taps: the 8-bit look-ahead and the 7 bits after an escape.
   assign look      = 8'(window_ff >> (held_ff - 5'd8));
   assign esc_bits  = 7'(window_ff >> (held_ff - 5'd7));
   assign have_bits = esc_ff ? (held_ff >= 5'd7) : (held_ff >= 5'd8);
   assign rd_ent    = nemtd_pkg::entry_type'(ram_rdata);
   assign count     = {hdr_hi_ff, req_data.stream_byte};

   // Code length zero or above eight counts as eight.
   assign code_len  = ((code_hdr_ff[3:0] == 4'd0) ||
                       (code_hdr_ff[3:0] > nemtd_pkg::MAX_CODE_LEN)) ?
                      nemtd_pkg::MAX_CODE_LEN : code_hdr_ff[3:0];
   assign shamt     = 3'(nemtd_pkg::MAX_CODE_LEN - code_len);

   always_comb begin
      unique case (state_ff)
         ST_WAIT, ST_HDR_LO, ST_TBL_FIRST, ST_TBL_BODY, ST_TBL_CODE: req_ready = 1'b1;
         ST_LOOK: req_ready = !have_bits;
         default: req_ready = 1'b0;
      endcase
   end
   assign accept = req_valid && req_ready;

   assign ram_we    = (state_ff == ST_FILL);
   assign ram_waddr = base_ff | {1'b0, fill_i_ff};

   always_comb begin
      state_in     = state_ff;
      esc_in       = esc_ff;
      hdr_hi_in    = hdr_hi_ff;
      xor_in       = xor_ff;
      sym_in       = sym_ff;
      code_hdr_in  = code_hdr_ff;
      window_in    = window_ff;
      held_in      = held_ff;
      valid_in     = valid_ff;
      base_in      = base_ff;
      fill_i_in    = fill_i_ff;
      fill_last_in = fill_last_ff;
      fill_ent_in  = fill_ent_ff;
      look_in      = look_ff;
      run_in       = run_ff;
      nyb_in       = nyb_ff;
      pk_ctl       = '0;
      pk_ctl.xor_en = xor_ff;
      pk_ctl.groups = {count, 3'd0};
      pk_ctl.nybble = nyb_ff;

      if (accept && req_data.frame_start) begin
         // A marked byte restarts the block, abandoning any stream.
         xor_in    = req_data.stream_byte[7];
         hdr_hi_in = req_data.stream_byte[6:0];
         window_in = 16'd0;
         held_in   = 5'd0;
         esc_in    = 1'b0;
         state_in  = ST_HDR_LO;
      end else begin
         unique case (state_ff)
            ST_WAIT: begin
               // drop unmarked bytes
            end
            ST_HDR_LO: begin
               if (accept) begin
                  if (count == 15'd0) begin
                     state_in = ST_WAIT;
                  end else begin
                     pk_ctl.load = 1'b1;
                     valid_in    = '0;
                     state_in    = ST_TBL_FIRST;
                  end
               end
            end
            ST_TBL_FIRST: begin
               if (accept) begin
                  if (req_data.stream_byte == nemtd_pkg::TABLE_END) begin
                     state_in = ST_LOOK;
                  end else begin
                     sym_in   = req_data.stream_byte[3:0];
                     state_in = ST_TBL_BODY;
                  end
               end
            end
            ST_TBL_BODY: begin
               if (accept) begin
                  if (req_data.stream_byte == nemtd_pkg::TABLE_END) begin
                     state_in = ST_LOOK;
                  end else if (req_data.stream_byte >= nemtd_pkg::SYMBOL_MARK) begin
                     sym_in = req_data.stream_byte[3:0];
                  end else begin
                     code_hdr_in = req_data.stream_byte;
                     state_in    = ST_TBL_CODE;
                  end
               end
            end
            ST_TBL_CODE: begin
               if (accept) begin
                  base_in      = 8'(req_data.stream_byte << shamt);
                  fill_i_in    = 7'd0;
                  fill_last_in = 7'((8'd1 << shamt) - 8'd1);
                  fill_ent_in  = '{code_len: code_len, run_m1: code_hdr_ff[6:4],
                                   nybble: sym_ff};
                  state_in     = ST_FILL;
               end
            end
            ST_FILL: begin
               // One table entry per cycle; mark it valid as it is written.
               valid_in[ram_waddr] = 1'b1;
               fill_i_in = fill_i_ff + 7'd1;
               if (fill_i_ff == fill_last_ff) begin
                  state_in = ST_TBL_BODY;
               end
            end
            ST_LOOK: begin
               if (accept) begin
                  window_in = {window_ff[7:0], req_data.stream_byte};
                  held_in   = held_ff + 5'd8;
               end else if (have_bits) begin
                  if (esc_ff) begin
                     run_in   = esc_bits[6:4];
                     nyb_in   = esc_bits[3:0];
                     held_in  = held_ff - 5'd7;
                     esc_in   = 1'b0;
                     state_in = ST_EMIT;
                  end else begin
                     look_in  = look;
                     state_in = ST_TBL_READ;
                  end
               end
            end
            ST_TBL_READ: begin
               if (valid_ff[look_ff]) begin
                  held_in  = held_ff - 5'(rd_ent.code_len);
                  run_in   = rd_ent.run_m1;
                  nyb_in   = rd_ent.nybble;
                  state_in = ST_EMIT;
               end else if (look_ff[7:2] == nemtd_pkg::ESCAPE_CODE) begin
                  held_in  = held_ff - 5'd6;
                  esc_in   = 1'b1;
                  state_in = ST_LOOK;
               end else begin
                  // Unknown code: skip one bit.
                  held_in  = held_ff - 5'd1;
                  state_in = ST_LOOK;
               end
            end
            ST_EMIT: begin
               if (pk_sts.ready) begin
                  pk_ctl.push = 1'b1;
                  run_in      = run_ff - 3'd1;
                  if (pk_sts.final_) begin
                     state_in = ST_WAIT;
                  end else if (run_ff == 3'd0) begin
                     state_in = ST_LOOK;
                  end
               end
            end
            default: state_in = ST_WAIT;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_WAIT;
         esc_ff   <= 1'b0;
         held_ff  <= 5'd0;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         esc_ff   <= esc_in;
         held_ff  <= held_in;
         valid_ff <= valid_in;
      end
      hdr_hi_ff    <= hdr_hi_in;
      xor_ff       <= xor_in;
      sym_ff       <= sym_in;
      code_hdr_ff  <= code_hdr_in;
      window_ff    <= window_in;
      base_ff      <= base_in;
      fill_i_ff    <= fill_i_in;
      fill_last_ff <= fill_last_in;
      fill_ent_ff  <= fill_ent_in;
      look_ff      <= look_in;
      run_ff       <= run_in;
      nyb_ff       <= nyb_in;
   end

   nemtd_ram #(
      .WIDTH (nemtd_pkg::ENTRY_W),
      .DEPTH (nemtd_pkg::TABLE_ENTRIES)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (fill_ent_ff),
      .raddr (look),
      .rdata (ram_rdata)
   );

   nemtd_word_packer u_packer (
      .clock     (clock),
      .reset     (reset),
      .ctl       (pk_ctl),
      .sts       (pk_sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

>>> sv/nemtd_checker.sv
// Port-level checks on the tile decompressor, bound to the top level.
// Depends on nemtd_pkg and nemesis_tile_decompressor_top.
module nemtd_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input nemtd_pkg::req_type req_data,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input nemtd_pkg::rsp_type rsp_data
);

   // Hold a stalled result transaction.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result transaction dropped or changed while stalled");

   // Come out of reset idle and waiting for input.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

   // Words are produced only while input is held off.
   a_word_while_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("word produced while input was being taken");

endmodule

bind nemesis_tile_decompressor_top nemtd_checker u_nemtd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

>>> tb/tb_nemesis_tile_decompressor_top.sv
// Self-checking testbench for the tile decompressor: drives compressed streams
// with random idle bursts on both handshakes and checks every tile word.
// Depends on nemtd_pkg and nemesis_tile_decompressor_top.
module tb_nemesis_tile_decompressor_top;

   typedef enum logic [2:0] {
      PH_WAIT, PH_HDR_LO, PH_TBL_FIRST, PH_TBL_BODY, PH_TBL_CODE, PH_DECODE, PH_ESCAPE
   } phase_type;

   localparam int unsigned STALL_LIMIT = 20000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   nemtd_pkg::req_type req_data = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   nemtd_pkg::rsp_type rsp_data;

   nemesis_tile_decompressor_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #10 clock = ~clock;

   // Pending input transactions, and the tile words they should produce.
   nemtd_pkg::req_type byte_queue[$];
   nemtd_pkg::rsp_type tile_queue[$];
   int        failures = 0;
   bit        stim_done = 1'b0;
   bit        calm = 1'b0;      // no idling in the closing part of the run
   int        watchdog = 0;

   // Decoder state mirrored in the testbench.
   phase_type   ph = PH_WAIT;
   logic        xor_on = 1'b0;
   logic [17:0] groups = '0;
   logic [3:0]  symbol = '0;
   logic [7:0]  code_hdr = '0;
   logic [11:0] lut[256];
   logic [15:0] window = '0;
   int unsigned held = 0;
   logic [31:0] acc = '0;
   int unsigned nyb_count = 0;
   logic [31:0] prev_word = '0;

   // Append run copies of a nybble; return 0 once the last word is out.
   function automatic bit push_nybbles(logic [3:0] nyb, int unsigned run);
      nemtd_pkg::rsp_type r;
      for (int i = 0; i < run; i++) begin
         acc = {acc[27:0], nyb};
         nyb_count++;
         if (nyb_count == 8) begin
            r.tile_word = acc;
            if (xor_on) begin
               r.tile_word = acc ^ prev_word;
               prev_word = r.tile_word;
            end
            acc = '0;
            nyb_count = 0;
            groups = groups - 1'b1;
            r.last_word = (groups == 0);
            tile_queue.push_back(r);
            if (groups == 0) begin
               ph = PH_WAIT;
               return 1'b0;
            end
         end
      end
      return 1'b1;
   endfunction

   function automatic void fill_lut(logic [7:0] code);
      int unsigned len;
      logic [7:0]  base;
      len = code_hdr[3:0];
      if (len == 0 || len > 8) len = 8;
      base = code << (8 - len);
      for (int i = 0; i < (1 << (8 - len)); i++)
         lut[base | i] = {1'b1, 4'(len), code_hdr[6:4], symbol};
   endfunction

   function automatic void run_decoder();
      logic [7:0]  look;
      logic [11:0] ent;
      while (groups != 0) begin
         if (ph == PH_ESCAPE) begin
            if (held < 7) break;
            ph = PH_DECODE;
            if (!push_nybbles(4'(window >> (held - 7)), 32'(3'(window >> (held - 3))) + 1)) begin
               held -= 7;
               break;
            end
            held -= 7;
         end else begin
            if (held < 8) break;
            look = 8'(window >> (held - 8));
            ent = lut[look];
            if (ent[11]) begin
               held -= ent[10:7];
               if (!push_nybbles(ent[3:0], 32'(ent[6:4]) + 1)) break;
            end else if (look[7:2] == nemtd_pkg::ESCAPE_CODE) begin
               held -= 6;
               ph = PH_ESCAPE;
            end else begin
               held -= 1;
            end
         end
      end
   endfunction

   // Advance the mirrored decoder by one accepted byte.
   function automatic void predict_byte(nemtd_pkg::req_type t);
      logic [7:0] b;
      b = t.stream_byte;
      if (t.frame_start) begin
         xor_on = b[7];
         groups = {3'b0, b[6:0], 8'h00};
         window = '0; held = 0; acc = '0; nyb_count = 0; prev_word = '0;
         ph = PH_HDR_LO;
         return;
      end
      case (ph)
         PH_HDR_LO: begin
            groups = (groups | 18'(b)) << 3;
            if (groups == 0) ph = PH_WAIT;
            else begin
               foreach (lut[i]) lut[i] = '0;
               ph = PH_TBL_FIRST;
            end
         end
         PH_TBL_FIRST: begin
            if (b == nemtd_pkg::TABLE_END) ph = PH_DECODE;
            else begin
               symbol = b[3:0];
               ph = PH_TBL_BODY;
            end
         end
         PH_TBL_BODY: begin
            if (b == nemtd_pkg::TABLE_END) ph = PH_DECODE;
            else if (b >= nemtd_pkg::SYMBOL_MARK) symbol = b[3:0];
            else begin
               code_hdr = b;
               ph = PH_TBL_CODE;
            end
         end
         PH_TBL_CODE: begin
            fill_lut(b);
            ph = PH_TBL_BODY;
         end
         PH_DECODE, PH_ESCAPE: begin
            window = {window[7:0], b};
            held += 8;
            run_decoder();
         end
         default: ;
      endcase
   endfunction

   function automatic void send(logic [7:0] b, logic s = 1'b0);
      nemtd_pkg::req_type t;
      t.stream_byte = b;
      t.frame_start = s;
      byte_queue.push_back(t);
   endfunction

   // One stream: header, a random code table, then payload bytes.
   function automatic void build_stream(int tiles_hi, int tiles_lo, bit xr, int payload);
      int ncodes;
      send({xr, 7'(tiles_hi)}, 1'b1);
      send(8'(tiles_lo));
      send(8'h80 | 8'($urandom_range(0, 15)));
      ncodes = $urandom_range(1, 6);
      for (int i = 0; i < ncodes; i++) begin
         if ($urandom_range(0, 3) == 0) send(8'h80 | 8'($urandom_range(0, 127)));
         // code lengths 2 to 8 only, so no table write covers more than 64 entries
         send(8'($urandom_range(0, 7) << 4) | 8'($urandom_range(2, 8)));
         send(8'($urandom_range(0, 255)));
      end
      send(nemtd_pkg::TABLE_END);
      for (int i = 0; i < payload; i++) send(8'($urandom_range(0, 255)));
   endfunction

   // Driver: present queued transactions, with idle bursts.
   int req_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_byte(req_data);
            void'(byte_queue.pop_front());
         end
         if (req_valid && !req_ready) begin
            // hold payload until the transaction completes
         end else if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_valid <= 1'b0;
         end else if (byte_queue.size() > 0) begin
            if (!calm && $urandom_range(0, 5) == 0) begin
               req_gap <= $urandom_range(0, 5);
               req_valid <= 1'b0;
            end else begin
               req_valid <= 1'b1;
               req_data <= byte_queue[0];
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: random stalls, compare each tile word with the oldest expected.
   int rsp_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (tile_queue.size() == 0) begin
               $error("unexpected tile word %h", rsp_data.tile_word);
               failures++;
            end else begin
               if (rsp_data.tile_word !== tile_queue[0].tile_word) begin
                  $error("tile_word expected %h actual %h",
                         tile_queue[0].tile_word, rsp_data.tile_word);
                  failures++;
               end
               if (rsp_data.last_word !== tile_queue[0].last_word) begin
                  $error("last_word expected %b actual %b",
                         tile_queue[0].last_word, rsp_data.last_word);
                  failures++;
               end
               void'(tile_queue.pop_front());
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 6) == 0) begin
            rsp_gap <= $urandom_range(0, 5);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
         // count cycles in which no transaction completes
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) watchdog <= 0;
         else watchdog <= watchdog + 1;
      end
   end

   initial begin
      foreach (lut[i]) lut[i] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero tile count, ignored stray bytes, restart mid-stream,
      // code lengths of one, zero and over eight, escapes, unknown codes.
      send(8'h00, 1'b1); send(8'h00);
      send(8'h55); send(8'hAA);
      send(8'h00, 1'b1); send(8'h01);
      send(8'h7F); send(8'h00); send(8'h81); send(8'h0F); send(8'hFF);  // short first byte
      send(8'h80, 1'b1); send(8'h01); send(8'h93); send(8'h71); send(8'h01);
      send(8'h85); send(8'h00); send(8'hFE); send(8'h8A); send(8'h09); send(8'hFF);
      send(8'hFF);
      send(8'h30); send(8'hFC); send(8'hFF); send(8'h00); send(8'hFD); send(8'h5A);
      for (int i = 0; i < 14; i++) send(8'h00);

      // Random streams: mostly well formed, mostly one tile (else 32513); occasional noise.
      for (int k = 0; k < 6; k++) begin
         if ($urandom_range(0, 4) == 0) begin
            for (int i = 0; i < 3; i++)
               send(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         end
         build_stream(($urandom_range(0, 9) == 0) ? 127 : 0, 1,
                      1'($urandom_range(0, 1)), 16);
      end
      // Largest count once, abandoned by a restart.
      send(8'hFF, 1'b1); send(8'hFF); send(8'h80); send(8'h18); send(8'h00);
      send(8'hFF); for (int i = 0; i < 6; i++) send(8'h00);

      // Closing stretch with no idling on either side.
      wait (byte_queue.size() == 0);
      calm = 1'b1;
      build_stream(0, 1, 1'b1, 20);
      wait (byte_queue.size() == 0 && !req_valid);
      wait (tile_queue.size() == 0);
      repeat (50) @(posedge clock);
      if (failures == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

   always @(posedge clock) begin
      if (watchdog >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

endmodule

>>> filelist.f
sv/nemtd_pkg.sv
sv/nemtd_ram.sv
sv/nemtd_word_packer.sv
sv/nemesis_tile_decompressor_top.sv
sv/nemtd_checker.sv
tb/tb_nemesis_tile_decompressor_top.sv
